// ===== rtl/sbmq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared constants, codes and types of the shared-buffer multi-queue.
// ----------------------------------------------------------------------------
package sbmq_pkg;

    localparam int SLOTS      = 16;
    localparam int QUEUES     = 4;
    localparam int DATA_WIDTH = 32;

    // payload field widths
    localparam int QNUM_W    = 2;
    localparam int DATA_IO_W = 32;
    localparam int STATUS_W  = 2;

    // slot index, link (slot index plus the null value) and queue index widths
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_W  = $clog2(SLOTS + 1);
    localparam int QUEUE_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic capture;  // take the incoming request into the datapath
        logic exec;     // unlink / link step, data store access
        logic load;     // finish step, result into the output register
    } t_cmd;

endpackage
`default_nettype wire

// ===== rtl/shared_buffer_multi_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue
// Four FIFO queues linked through one shared store of 16 slots.
// ----------------------------------------------------------------------------
// Each request (enqueue or dequeue on one queue) gives exactly one response,
// in order. A request runs an unlink/link step on the head, tail and
// free-list registers with the data store access, then a finish step
// that terminates the new tail link and loads the response register.
// A request may be taken on the edge the previous one finishes, so only
// one request is in work at a time; a stalled response holds back the
// finish step. The response register lets a new request in while the
// last response is still stalled. Link table and queue heads reset
// directly; there is no clearing pass. Status 1 means the store was full
// and the enqueue was dropped; status 2 means the queue was empty (data -1).
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic                                   i_mode,
    input  wire logic [sbmq_pkg::QNUM_W-1:0]            i_queue_number,
    input  wire logic signed [sbmq_pkg::DATA_IO_W-1:0]  i_data_in,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic signed [sbmq_pkg::DATA_IO_W-1:0]       o_data_out,
    output logic [sbmq_pkg::STATUS_W-1:0]               o_status
);

    sbmq_pkg::t_cmd cmd;

    sbmq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    sbmq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_mode         (i_mode),
        .i_queue_number (i_queue_number),
        .i_data_in      (i_data_in),
        .o_data_out     (o_data_out),
        .o_status       (o_status)
    );

    // an accepted request is worked on in the very next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> cmd.exec)
        else $error("accepted request not executed");

    // one request at a time: exec never runs in consecutive cycles
    a_single_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> !cmd.exec)
        else $error("overlapping requests");

    a_full_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == sbmq_pkg::ST_FULL) |-> (o_data_out == '0))
        else $error("full response with non-zero data");

    a_empty_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == sbmq_pkg::ST_EMPTY) |-> (o_data_out == '1))
        else $error("empty response without -1 data");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == sbmq_pkg::ST_OK || o_status == sbmq_pkg::ST_FULL
                         || o_status == sbmq_pkg::ST_EMPTY))
        else $error("bad status code");

endmodule
`default_nettype wire

// ===== rtl/sbmq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_ctrl
// Sequencer of the multi-queue: handshakes on both channels and the
// capture / exec / finish steps issued to the datapath.
// ----------------------------------------------------------------------------
module sbmq_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output sbmq_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       in_ready;
    logic       accept;

    assign out_free = !r_out_valid || !i_out_stall;
    // a new request may enter on the same edge the previous one finishes
    assign in_ready = (r_state == S_IDLE) || ((r_state == S_DONE) && out_free);
    assign accept   = i_in_valid && in_ready;

    assign o_in_stall   = !in_ready;
    assign o_out_valid  = r_out_valid;
    assign o_cmd.capture = accept;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.load    = (r_state == S_DONE) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/sbmq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sbmq_dp
// Datapath of the multi-queue: head/tail registers, link table, free-list
// head, slot data store and the result register.
// ----------------------------------------------------------------------------
module sbmq_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire sbmq_pkg::t_cmd                         i_cmd,
    input  wire logic                                   i_mode,
    input  wire logic [sbmq_pkg::QNUM_W-1:0]            i_queue_number,
    input  wire logic signed [sbmq_pkg::DATA_IO_W-1:0]  i_data_in,
    output logic signed [sbmq_pkg::DATA_IO_W-1:0]       o_data_out,
    output logic [sbmq_pkg::STATUS_W-1:0]               o_status
);

    // captured request
    logic                                 r_mode;
    logic [sbmq_pkg::QNUM_W-1:0]          r_q;
    logic [sbmq_pkg::DATA_WIDTH-1:0]      r_din;

    // carried from exec to finish
    logic [sbmq_pkg::SLOT_W-1:0]          r_slot;
    logic                                 r_fail;
    logic [sbmq_pkg::DATA_WIDTH-1:0]      r_rd;

    // queue and free-list state
    logic [sbmq_pkg::LINK_W-1:0]          r_head [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::SLOT_W-1:0]          r_tail [sbmq_pkg::QUEUES];
    logic [sbmq_pkg::LINK_W-1:0]          r_link [sbmq_pkg::SLOTS];
    logic [sbmq_pkg::LINK_W-1:0]          r_free;
    logic [sbmq_pkg::DATA_WIDTH-1:0]      mem_data [sbmq_pkg::SLOTS];

    logic signed [sbmq_pkg::DATA_IO_W-1:0] r_data_out;
    logic [sbmq_pkg::STATUS_W-1:0]         r_status;

    logic [sbmq_pkg::QUEUE_W-1:0]         qi;
    logic                                 q_ok;
    logic [sbmq_pkg::LINK_W-1:0]          head_q;
    logic                                 head_null;
    logic                                 free_null;
    logic                                 is_enq;
    logic                                 fail;
    logic [sbmq_pkg::SLOT_W-1:0]          slot;

    assign qi        = r_q[sbmq_pkg::QUEUE_W-1:0];
    assign q_ok      = (32'(r_q) < sbmq_pkg::QUEUES);
    assign head_q    = r_head[qi];
    assign head_null = (head_q >= sbmq_pkg::NIL);
    assign free_null = (r_free >= sbmq_pkg::NIL);
    assign is_enq    = (r_mode == sbmq_pkg::MODE_ENQ);
    assign fail      = !q_ok || (is_enq ? free_null : head_null);
    // enqueue pops the free list, dequeue pops the addressed queue
    assign slot      = is_enq ? r_free[sbmq_pkg::SLOT_W-1:0]
                              : head_q[sbmq_pkg::SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_q    <= i_queue_number;
            r_din  <= i_data_in[sbmq_pkg::DATA_WIDTH-1:0];
        end
        if (i_cmd.exec) begin
            r_slot <= slot;
            r_fail <= fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < sbmq_pkg::QUEUES; i++) begin
                r_head[i] <= sbmq_pkg::NIL;
            end
            for (int i = 0; i < sbmq_pkg::SLOTS; i++) begin
                r_link[i] <= sbmq_pkg::LINK_W'(i + 1);
            end
            r_free <= '0;
        end else if (i_cmd.exec && !fail) begin
            if (is_enq) begin
                r_free <= r_link[slot];
                if (head_null) begin
                    r_head[qi] <= sbmq_pkg::LINK_W'(slot);
                end else begin
                    r_link[r_tail[qi]] <= sbmq_pkg::LINK_W'(slot);
                end
            end else begin
                r_head[qi]   <= r_link[slot];
                r_link[slot] <= r_free;
                r_free       <= sbmq_pkg::LINK_W'(slot);
            end
        end else if (i_cmd.load && is_enq && !r_fail) begin
            // terminate the new tail
            r_link[r_slot] <= sbmq_pkg::NIL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !fail && is_enq) begin
            r_tail[qi] <= slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !fail) begin
            if (is_enq) begin
                mem_data[slot] <= r_din;
            end else begin
                r_rd <= mem_data[slot];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (is_enq) begin
                r_data_out <= '0;
                r_status   <= r_fail ? sbmq_pkg::ST_FULL : sbmq_pkg::ST_OK;
            end else if (r_fail) begin
                r_data_out <= '1;
                r_status   <= sbmq_pkg::ST_EMPTY;
            end else begin
                r_data_out <= sbmq_pkg::DATA_IO_W'(signed'(r_rd));
                r_status   <= sbmq_pkg::ST_OK;
            end
        end
    end

    assign o_data_out = r_data_out;
    assign o_status   = r_status;

endmodule
`default_nettype wire
